// ===== rtl/dfc_pkg.sv =====
// shared constants, types and codes for the damped fir convolver
package dfc_pkg;

  // sizing
  localparam int MAX_TAPS   = 2048;
  localparam int CHANNELS   = 2;
  localparam int TAP_W      = $clog2(MAX_TAPS);
  localparam int LEN_W      = $clog2(MAX_TAPS + 1);
  localparam int CH_IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_DEPTH = CHANNELS * MAX_TAPS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 18;
  localparam int DAMP_W     = 16;
  localparam int TAPCNT_W   = 12;
  localparam int CIDX_W     = 11;

  // taper arithmetic: r(i) = floor(DAMP_K * damp * i / (2^16 * L))
  localparam int FRAC_W     = 16;
  localparam int DAMP_K     = 58982;
  localparam int NUM_W      = 2 * DAMP_W;
  localparam int QUOT_W     = NUM_W - FRAC_W;
  localparam int REM0_W     = LEN_W + FRAC_W;
  localparam int RACC_W     = REM0_W + 1;
  localparam int TAPER_W    = FRAC_W + 1;
  localparam int TAPER_ONE  = 1 << FRAC_W;

  // mac datapath
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SCALED_W   = PROD_W + TAPER_W + 1;
  localparam int TERM_W     = SCALED_W - FRAC_W;
  localparam int ACC_W      = TERM_W + LEN_W;

  // output rounding and saturation
  localparam int OUT_SHIFT  = 17;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(65536);
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-8388608);

  // item actions
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // register map, index taken from paddr[2]
  localparam logic [0:0] REG_DAMP      = 1'b0;
  localparam logic [0:0] REG_TAP_COUNT = 1'b1;
  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = TAPCNT_W'(16);
  localparam int PADDR_W = 3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } dfc_state_t;

  // control from sequencer to the mac unit
  typedef struct packed {
    logic clear;
    logic issue;
    logic hist_ok;
  } mac_ctl_t;

endpackage

// ===== rtl/dfc_if.sv =====
// item and result channel interfaces of the damped fir convolver

interface dfc_item_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic               channel;
  logic signed [23:0] sample;
  logic               bad_sample;
  logic [10:0]        coef_index;
  logic signed [17:0] coef_value;

  modport source (
    output valid, action, channel, sample, bad_sample, coef_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, action, channel, sample, bad_sample, coef_index, coef_value,
    output ready
  );
endinterface

interface dfc_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_sample;
  logic               out_channel;

  modport source (
    output valid, out_sample, out_channel,
    input  ready
  );
  modport sink (
    input  valid, out_sample, out_channel,
    output ready
  );
endinterface

// ===== rtl/dfc_ram.sv =====
// generic simple dual-port ram with registered read
module dfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dfc_div.sv =====
// restoring divider, one quotient bit per cycle, for the taper step
module dfc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dfc_pkg::QUOT_W-1:0]    dividend,
  input  logic [dfc_pkg::LEN_W-1:0]     divisor,
  output logic                          done,
  output logic [dfc_pkg::QUOT_W-1:0]    quot,
  output logic [dfc_pkg::LEN_W-1:0]     rem
);
  import dfc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             fits;

  // one trial subtraction
  always_comb begin
    shifted = {rem, quot[QUOT_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QUOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // quotient shifts in over the dividend, remainder builds up
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[QUOT_W-2:0], fits};
      rem  <= fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
    end
  end

endmodule

// ===== rtl/dfc_mac.sv =====
// pipelined tap multiply, taper scaling and accumulate
module dfc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dfc_pkg::mac_ctl_t                    ctl,
  input  logic [dfc_pkg::TAPER_W-1:0]          taper,
  input  logic signed [dfc_pkg::SAMPLE_W-1:0]  hist_data,
  input  logic signed [dfc_pkg::COEF_W-1:0]    coef_data,
  output logic                                 busy,
  output logic signed [dfc_pkg::ACC_W-1:0]     acc
);
  import dfc_pkg::*;

  logic                        v1, v2, v3;
  logic                        ok1;
  logic [TAPER_W-1:0]          taper1, taper2;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SCALED_W-1:0]  scaled;
  logic signed [TERM_W-1:0]    term;

  assign busy = v1 | v2 | v3;

  // valid pipe, aligned with the ram read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // side data that waits for the ram
  always_ff @(posedge clk) begin
    ok1    <= ctl.hist_ok;
    taper1 <= taper;
  end

  // stage a: sample times coefficient, unwritten history reads as zero
  always_ff @(posedge clk) begin
    if (v1) begin
      if (ok1) begin
        prod <= PROD_W'(hist_data) * PROD_W'(coef_data);
      end else begin
        prod <= '0;
      end
      taper2 <= taper1;
    end
  end

  // stage b: scale by the taper, floor to q4.40
  assign scaled = SCALED_W'(prod) * SCALED_W'($signed({1'b0, taper2}));

  always_ff @(posedge clk) begin
    if (v2) begin
      term <= scaled[SCALED_W-1:FRAC_W];
    end
  end

  // stage c: accumulate
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc <= '0;
    end else if (v3) begin
      acc <= acc + ACC_W'(term);
    end
  end

endmodule

// ===== rtl/damped_fir_convolver_unit.sv =====
// top level: damped fir convolver with shared mac unit and tap sequencer
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------------------
//  item     | in  | valid / ready  | action, channel, sample, bad_sample,
//           |     |                | coef_index, coef_value
//  result   | out | valid / ready  | out_sample, out_channel
//  apb      | in  | psel / penable | paddr 0 = damp, paddr 4 = tap_count
//
// a load item is taken in the idle state; a sample item holds ready low (L is tap_count
// clamped to 1..MAX_TAPS) through the history write, divider start, the taper divider,
// the L taps at one tap per cycle through the shared mac unit, a drain and rounding.
// reset clears write positions and wrap flags; unwritten history reads as zero via the flag.
// a waiting result sits in the output register while the next item is taken; a second
// result waits in the rounding state until that register frees up.
module damped_fir_convolver_unit (
  input  logic                           clk,
  input  logic                           rst,
  dfc_item_if.sink                       item,
  dfc_result_if.source                   result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dfc_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dfc_pkg::*;

  // configuration
  logic [DAMP_W-1:0]   damp;
  logic [TAPCNT_W-1:0] tap_count;
  logic [0:0]          cfg_index;
  logic                cfg_write;

  // sequencer
  dfc_state_t state, state_next;
  logic       accept;
  logic       start_sample;
  logic       div_start;
  logic       round_load;
  mac_ctl_t   mac_ctl;

  // per-item registers
  logic [CH_IW-1:0]           ch_sel;
  logic                       ch_out;
  logic signed [SAMPLE_W-1:0] sample_eff;
  logic [LEN_W-1:0]           len;
  logic [TAP_W-1:0]           wp_cur;
  logic                       wrapped_cur;
  logic [NUM_W-1:0]           num;
  logic [LEN_W-1:0]           tap_i;
  logic [TAP_W-1:0]           rd_idx;
  logic [QUOT_W-1:0]          r_q;
  logic [RACC_W-1:0]          r_acc;

  // per-channel state
  logic [TAP_W-1:0] wp      [CHANNELS];
  logic             wrapped [CHANNELS];

  // divider
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [LEN_W-1:0]  div_rem;

  // taper step
  logic [REM0_W-1:0]  rem0;
  logic [REM0_W-1:0]  d_full;
  logic [RACC_W-1:0]  r_sum;
  logic               r_carry;
  logic [TAPER_W-1:0] taper;

  // memories
  logic                       hist_we;
  logic [HIST_AW-1:0]         hist_waddr, hist_raddr;
  logic signed [SAMPLE_W-1:0] hist_rdata;
  logic                       coef_we;
  logic signed [COEF_W-1:0]   coef_rdata;

  // mac and output
  logic                    mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                    out_valid;

  // apb register port
  assign pready    = 1'b1;
  assign cfg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      damp      <= '0;
      tap_count <= TAP_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DAMP:      damp      <= pwdata[DAMP_W-1:0];
        REG_TAP_COUNT: tap_count <= pwdata[TAPCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_DAMP:      prdata = {{(32-DAMP_W){1'b0}}, damp};
      REG_TAP_COUNT: prdata = {{(32-TAPCNT_W){1'b0}}, tap_count};
      default:       prdata = '0;
    endcase
  end

  // item handshake
  assign item.ready   = (state == ST_IDLE);
  assign accept       = item.valid && item.ready;
  assign start_sample = accept && (item.action == ACT_SAMPLE) &&
                        (int'(item.channel) < CHANNELS);
  assign coef_we      = accept && (item.action == ACT_LOAD) &&
                        (int'(item.coef_index) < MAX_TAPS);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next      = state;
    div_start       = 1'b0;
    hist_we         = 1'b0;
    round_load      = 1'b0;
    mac_ctl.clear   = 1'b0;
    mac_ctl.issue   = 1'b0;
    mac_ctl.hist_ok = wrapped_cur || (rd_idx <= wp_cur);
    unique case (state)
      ST_IDLE: begin
        if (start_sample) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        hist_we    = 1'b1;
        state_next = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start     = 1'b1;
        mac_ctl.clear = 1'b1;
        state_next    = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        mac_ctl.issue = 1'b1;
        if (tap_i == len - 1'b1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid || result.ready) begin
          round_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // capture the sample item
  always_ff @(posedge clk) begin
    if (start_sample) begin
      ch_sel      <= CH_IW'(item.channel);
      ch_out      <= item.channel;
      sample_eff  <= item.bad_sample ? '0 : item.sample;
      wp_cur      <= wp[CH_IW'(item.channel)];
      wrapped_cur <= wrapped[CH_IW'(item.channel)];
      if (tap_count == '0) begin
        len <= LEN_W'(1);
      end else if (int'(tap_count) > MAX_TAPS) begin
        len <= LEN_W'(MAX_TAPS);
      end else begin
        len <= LEN_W'(tap_count);
      end
    end
  end

  // damping numerator, 0.9 * damp in q0.16 scale
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      num <= NUM_W'(DAMP_K) * NUM_W'(damp);
    end
  end

  // write position advance and wrap flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp[c]      <= '0;
        wrapped[c] <= 1'b0;
      end
    end else if (state == ST_PREP) begin
      if (int'(wp_cur) == MAX_TAPS - 1) begin
        wp[ch_sel]      <= '0;
        wrapped[ch_sel] <= 1'b1;
      end else begin
        wp[ch_sel] <= wp_cur + 1'b1;
      end
    end
  end

  // taper step: r tracks floor(i * num / d_full) with remainder r_acc
  assign rem0    = {div_rem, num[FRAC_W-1:0]};
  assign d_full  = {len, {FRAC_W{1'b0}}};
  assign r_sum   = r_acc + RACC_W'(rem0);
  assign r_carry = (r_sum >= RACC_W'(d_full));
  assign taper   = TAPER_W'(TAPER_ONE) - TAPER_W'(r_q);

  // tap counters
  always_ff @(posedge clk) begin
    if (state == ST_DIVWAIT) begin
      tap_i  <= '0;
      rd_idx <= wp_cur;
      r_q    <= '0;
      r_acc  <= '0;
    end else if (state == ST_RUN) begin
      tap_i  <= tap_i + 1'b1;
      rd_idx <= (rd_idx == '0) ? TAP_W'(MAX_TAPS - 1) : rd_idx - 1'b1;
      if (r_carry) begin
        r_acc <= r_sum - RACC_W'(d_full);
        r_q   <= r_q + div_quot + 1'b1;
      end else begin
        r_acc <= r_sum;
        r_q   <= r_q + div_quot;
      end
    end
  end

  // memory addressing
  assign hist_waddr = HIST_AW'(ch_sel) * HIST_AW'(MAX_TAPS) + HIST_AW'(wp_cur);
  assign hist_raddr = HIST_AW'(ch_sel) * HIST_AW'(MAX_TAPS) + HIST_AW'(rd_idx);

  dfc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (sample_eff),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  dfc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (TAP_W'(item.coef_index)),
    .wdata (item.coef_value),
    .raddr (TAP_W'(tap_i)),
    .rdata (coef_rdata)
  );

  dfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num[NUM_W-1:FRAC_W]),
    .divisor  (len),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  dfc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .taper     (taper),
    .hist_data (hist_rdata),
    .coef_data (coef_rdata),
    .busy      (mac_busy),
    .acc       (acc)
  );

  // round half up to q1.23 and saturate
  always_comb begin
    y_full = (acc + ROUND_BIAS) >>> OUT_SHIFT;
    if (y_full > SAT_HI) begin
      y_sat = SAMPLE_W'(SAT_HI);
    end else if (y_full < SAT_LO) begin
      y_sat = SAMPLE_W'(SAT_LO);
    end else begin
      y_sat = y_full[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (round_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (round_load) begin
      result.out_sample  <= y_sat;
      result.out_channel <= ch_out;
    end
  end

  assign result.valid = out_valid;

endmodule
